[sv/tnc_pkg.sv]
// Shared types and constants of the tag nesting checker.
package tnc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [TAG_W:0]   SLASH_CODE = (TAG_W + 1)'(47);
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  typedef enum logic {
    OP_OPEN,
    OP_CLOSE
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [TAG_W-1:0] code;
    logic             last;
  } tnc_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_EMIT
  } back_state_e;

endpackage

[sv/tnc_ifs.sv]
// Handshake channels for tag items and check results.
interface tnc_tok_if;
  import tnc_pkg::*;
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] tag_code;
  logic             is_close;
  logic             last;

  modport source (output valid, tag_code, is_close, last, input ready);
  modport sink   (input valid, tag_code, is_close, last, output ready);
endinterface

interface tnc_res_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic overflow;

  modport source (output valid, valid_res, overflow, input ready);
  modport sink   (input valid, valid_res, overflow, output ready);
endinterface

[sv/tag_nesting_checker_core.sv]
// Flow: items enter the queue; the stack engine takes an open tag in its idle state and
// a close tag that drops k entries in idle and k pop states (one stack RAM read per entry).
// A last item passes the emit state, which waits for a free output register and loads
// the result into it. Throughput: one item per engine pass; the queue accepts until full.
// Reset: asynchronous, active low; clears queue, counters, flags and stack level, the
// stack RAM itself is not cleared and needs no clearing pass.
module tag_nesting_checker_core #(
  parameter int unsigned STACK_DEPTH = tnc_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tnc_tok_if.sink   tok_i,
  tnc_res_if.source res_o
);
  import tnc_pkg::*;

  logic    q_valid;
  logic    q_pop;
  tnc_op_t q_op;

  tnc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_i     (tok_i),
    .q_valid_o (q_valid),
    .q_op_o    (q_op),
    .q_pop_i   (q_pop)
  );

  tnc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (q_op),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

[sv/tnc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tnc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/tnc_front.sv]
// Front end: accept tag items, classify them and queue them for the stack engine.
module tnc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  tnc_tok_if.sink          tok_i,
  output logic             q_valid_o,
  output tnc_pkg::tnc_op_t q_op_o,
  input  logic             q_pop_i
);
  import tnc_pkg::*;

  tnc_op_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push;
  tnc_op_t           op_in;

  assign tok_i.ready = (cnt_q != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push        = tok_i.valid && tok_i.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign q_op_o      = mem_q[rd_ptr_q];

  always_comb begin
    op_in.kind = tok_i.is_close ? OP_CLOSE : OP_OPEN;
    op_in.code = tok_i.tag_code;
    op_in.last = tok_i.last;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op_in;
    end
  end

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

[sv/tnc_back.sv]
// Back end: stack engine that pushes, pops and matches tags and forms the result.
module tnc_back #(
  parameter int unsigned STACK_DEPTH = tnc_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  tnc_pkg::tnc_op_t q_op_i,
  output logic             q_pop_o,
  tnc_res_if.source        res_o
);
  import tnc_pkg::*;

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);

  back_state_e      state_q, state_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [CNT_W-1:0] tok_cnt_q, tok_cnt_d;
  logic [CNT_W-1:0] cls_cnt_q, cls_cnt_d;
  logic             failed_q, failed_d;
  logic             ovf_q, ovf_d;
  logic [TAG_W-1:0] code_q, code_d;
  logic             last_q, last_d;

  logic             res_vld_q;
  logic             res_ok_q;
  logic             res_ovf_q;

  logic [LVL_W-1:0] lvl_m1, lvl_m2;
  logic             we, re;
  logic [AW-1:0]    raddr;
  logic [TAG_W-1:0] top;
  logic             match;
  logic             out_free;
  logic             load_res;

  assign lvl_m1   = level_q - 1'b1;
  assign lvl_m2   = level_q - LVL_W'(2);
  assign match    = ({1'b0, top} + SLASH_CODE) == {1'b0, code_q};
  assign out_free = !res_vld_q || res_o.ready;

  tnc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (level_q[AW-1:0]),
    .wdata_i (q_op_i.code),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (top)
  );

  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    tok_cnt_d = tok_cnt_q;
    cls_cnt_d = cls_cnt_q;
    failed_d  = failed_q;
    ovf_d     = ovf_q;
    code_d    = code_q;
    last_d    = last_q;
    q_pop_o   = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    raddr     = lvl_m1[AW-1:0];
    load_res  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          code_d  = q_op_i.code;
          last_d  = q_op_i.last;
          state_d = q_op_i.last ? ST_EMIT : ST_IDLE;
          // absorb items once the sequence has failed
          if (!failed_q) begin
            tok_cnt_d = (tok_cnt_q == COUNT_MAX) ? tok_cnt_q : tok_cnt_q + 1'b1;
            case (q_op_i.kind)
              OP_CLOSE: begin
                cls_cnt_d = (cls_cnt_q == COUNT_MAX) ? cls_cnt_q : cls_cnt_q + 1'b1;
                if (level_q == '0) begin
                  failed_d = 1'b1;
                end else begin
                  re      = 1'b1;
                  state_d = ST_POP;
                end
              end
              OP_OPEN: begin
                if (level_q == LVL_W'(STACK_DEPTH)) begin
                  ovf_d    = 1'b1;
                  failed_d = 1'b1;
                end else begin
                  we      = 1'b1;
                  level_d = level_q + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_POP: begin
        level_d = lvl_m1;
        if (match || level_q == LVL_W'(1)) begin
          failed_d = failed_q || !match;
          state_d  = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          // fetch the next entry down while this one is dropped
          re    = 1'b1;
          raddr = lvl_m2[AW-1:0];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_res  = 1'b1;
          level_d   = '0;
          tok_cnt_d = '0;
          cls_cnt_d = '0;
          failed_d  = 1'b0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      level_q   <= '0;
      tok_cnt_q <= '0;
      cls_cnt_q <= '0;
      failed_q  <= 1'b0;
      ovf_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      tok_cnt_q <= tok_cnt_d;
      cls_cnt_q <= cls_cnt_d;
      failed_q  <= failed_d;
      ovf_q     <= ovf_d;
      if (load_res) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    last_q <= last_d;
    if (load_res) begin
      res_ok_q  <= !failed_q && (cls_cnt_q <= (tok_cnt_q >> 1));
      res_ovf_q <= ovf_q;
    end
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.valid_res = res_ok_q;
  assign res_o.overflow  = res_ovf_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> level_q != '0)
    else $error("pop on an empty stack");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (level_q == '0 && tok_cnt_q == '0 && !failed_q))
    else $error("sequence state not cleared after result");

  a_close_le_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_cnt_q <= tok_cnt_q)
    else $error("more closes than items");

endmodule
